// ----- rtl/gbn_pkg.sv -----
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared constants, codes and helpers for the go-back-N send window.
// ----------------------------------------------------------------------------
package gbn_pkg;

    // Window geometry.
    localparam int WINDOW = 10;
    localparam int IDX_W  = 4;
    localparam int CNT_W  = 4;
    localparam int SUM_W  = CNT_W + 1;

    // Stream widths.
    localparam int IN_DATA_W  = 72;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 80;
    localparam int OUT_USER_W = 3;

    // One window entry: channel, handle, length and sequence number.
    localparam int ENTRY_W = 68;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Request codes.
    localparam logic [1:0] REQ_ENQ     = 2'd0;
    localparam logic [1:0] REQ_RESP    = 2'd1;
    localparam logic [1:0] REQ_TIMEOUT = 2'd2;
    localparam logic [1:0] REQ_TX      = 2'd3;

    // Result kind codes.
    localparam logic [2:0] KIND_TX     = 3'd0;
    localparam logic [2:0] KIND_ENQ    = 3'd1;
    localparam logic [2:0] KIND_FULL   = 3'd2;
    localparam logic [2:0] KIND_ACKED  = 3'd3;
    localparam logic [2:0] KIND_IGNORE = 3'd4;
    localparam logic [2:0] KIND_IDLE   = 3'd5;

    // Ring position base + offset, modulo the window; the sum stays below twice the window.
    function automatic idx_t wrap_add(input idx_t base, input cnt_t offs);
        logic [SUM_W-1:0] sum;
        sum = {1'b0, base} + {1'b0, offs};
        if (sum >= SUM_W'(WINDOW))
        begin
            sum = sum - SUM_W'(WINDOW);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// ----- rtl/go_back_n_send_window_core.sv -----
// ----------------------------------------------------------------------------
// go_back_n_send_window_core
// Go-back-N sender window held in a ring memory of WINDOW entries.
// ----------------------------------------------------------------------------
// The block takes one request item at a time. Enqueue, response and timeout
// items pass through the accept cycle, in which the window memory read is
// issued, and then the execute state, in which the registered read data is
// used and the result is loaded into the output register. A transmit pass
// emits its pending entries one entry a cycle from the single read port of
// the window memory while the result stream takes them; with nothing pending
// it gives one idle item. Back-pressure on the result stream holds the execute
// state while a result waits. A finished result can wait in the output
// register while the next request item is accepted.
module go_back_n_send_window_core
    import gbn_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // Fields from bit 0: channel(4), packet_handle(16), packet_len(16),
    // seq_num(32), zero pad(4).
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0: req_type(2), is_ack(1).
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Fields from bit 0: slot(4), channel_out(4), handle_out(16), len_out(16),
    // seq_out(32), occupancy(4), zero pad(4).
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // Fields from bit 0: result_kind(3).
    output logic [OUT_USER_W-1:0] m_axis_tuser,
    output logic                  m_axis_tlast
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;

    // Window control registers.
    idx_t head_reg, head_next;
    cnt_t held_reg, held_next;
    cnt_t sent_reg, sent_next;

    // Captured request.
    logic [1:0]  req_type_reg, req_type_next;
    logic [3:0]  chan_reg, chan_next;
    logic [15:0] handle_reg, handle_next;
    logic [15:0] len_reg, len_next;
    logic [31:0] seq_reg, seq_next;
    logic        ack_reg, ack_next;

    // Output register.
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic [OUT_USER_W-1:0] out_user_reg, out_user_next;
    logic                  out_last_reg, out_last_next;

    // Window memory and its port signals.
    logic [ENTRY_W-1:0] mem [WINDOW];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               rd_en;
    idx_t               rd_addr;
    logic               wr_en;
    idx_t               wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    // Result fields assembled before loading the output register.
    logic        out_free;
    logic        out_load;
    logic [2:0]  res_kind;
    idx_t        res_slot;
    logic [3:0]  res_chan;
    logic [15:0] res_handle;
    logic [15:0] res_len;
    logic [31:0] res_seq;
    logic        res_last;
    cnt_t        sent_inc;
    idx_t        tail;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign sent_inc = sent_reg + CNT_W'(1);
    assign tail     = wrap_add(head_reg, held_reg);

    // Sequencer: capture, then read-modify-write against the window memory.
    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        held_next     = held_reg;
        sent_next     = sent_reg;
        req_type_next = req_type_reg;
        chan_next     = chan_reg;
        handle_next   = handle_reg;
        len_next      = len_reg;
        seq_next      = seq_reg;
        ack_next      = ack_reg;
        rd_en         = 1'b0;
        rd_addr       = head_reg;
        wr_en         = 1'b0;
        wr_addr       = tail;
        wr_data       = {chan_reg, handle_reg, len_reg, seq_reg};
        out_load      = 1'b0;
        res_kind      = KIND_IDLE;
        res_slot      = head_reg;
        res_chan      = '0;
        res_handle    = '0;
        res_len       = '0;
        res_seq       = '0;
        res_last      = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    req_type_next = s_axis_tuser[1:0];
                    ack_next      = s_axis_tuser[2];
                    chan_next     = s_axis_tdata[3:0];
                    handle_next   = s_axis_tdata[19:4];
                    len_next      = s_axis_tdata[35:20];
                    seq_next      = s_axis_tdata[67:36];
                    rd_en         = 1'b1;
                    // Responses look at the head; a pass starts at the first unsent entry.
                    rd_addr       = (s_axis_tuser[1:0] == REQ_RESP) ?
                                    head_reg : wrap_add(head_reg, sent_reg);
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    unique case (req_type_reg)
                        REQ_ENQ:
                        begin
                            res_seq = seq_reg;
                            if (held_reg >= CNT_W'(WINDOW))
                            begin
                                res_kind = KIND_FULL;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                held_next = held_reg + CNT_W'(1);
                                res_kind  = KIND_ENQ;
                                res_slot  = tail;
                            end
                            state_next = ST_IDLE;
                        end
                        REQ_RESP:
                        begin
                            res_seq = seq_reg;
                            if ((held_reg != '0) && ack_reg && (rd_data_reg[31:0] == seq_reg))
                            begin
                                res_kind   = KIND_ACKED;
                                res_chan   = rd_data_reg[67:64];
                                res_handle = rd_data_reg[63:48];
                                res_len    = rd_data_reg[47:32];
                                head_next  = wrap_add(head_reg, CNT_W'(1));
                                held_next  = held_reg - CNT_W'(1);
                                if (sent_reg != '0)
                                begin
                                    sent_next = sent_reg - CNT_W'(1);
                                end
                            end
                            else
                            begin
                                res_kind = KIND_IGNORE;
                            end
                            state_next = ST_IDLE;
                        end
                        REQ_TIMEOUT:
                        begin
                            res_kind   = KIND_IGNORE;
                            sent_next  = '0;
                            state_next = ST_IDLE;
                        end
                        REQ_TX:
                        begin
                            if (sent_reg >= held_reg)
                            begin
                                res_kind   = KIND_IDLE;
                                state_next = ST_IDLE;
                            end
                            else
                            begin
                                // Emit the entry held in the read register and fetch the next one.
                                res_kind   = KIND_TX;
                                res_slot   = wrap_add(head_reg, sent_reg);
                                res_chan   = rd_data_reg[67:64];
                                res_handle = rd_data_reg[63:48];
                                res_len    = rd_data_reg[47:32];
                                res_seq    = rd_data_reg[31:0];
                                sent_next  = sent_inc;
                                res_last   = (sent_inc >= held_reg);
                                if (sent_inc >= held_reg)
                                begin
                                    state_next = ST_IDLE;
                                end
                                else
                                begin
                                    rd_en   = 1'b1;
                                    rd_addr = wrap_add(head_reg, sent_inc);
                                end
                            end
                        end
                    endcase
                end
            end
        endcase
    end

    // Output register: loaded with a new result, cleared when taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {4'b0000, held_next, res_seq, res_len, res_handle,
                              res_chan, res_slot};
            out_user_next  = res_kind;
            out_last_next  = res_last;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            held_reg      <= '0;
            sent_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            held_reg      <= held_next;
            sent_reg      <= sent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_type_reg <= req_type_next;
        chan_reg     <= chan_next;
        handle_reg   <= handle_next;
        len_reg      <= len_next;
        seq_reg      <= seq_next;
        ack_reg      <= ack_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    // Window memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/gbn_checker.sv -----
// ----------------------------------------------------------------------------
// gbn_checker
// Port-level checks on the result stream of the go-back-N send window.
// ----------------------------------------------------------------------------
module gbn_checker
    import gbn_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [OUT_USER_W-1:0] m_axis_tuser,
    input logic                  m_axis_tlast
);

    // A stalled result holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // Occupancy never exceeds the window.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[75:72] <= 4'(WINDOW))
        else $error("occupancy above window");

    // Only a transmit pass gives more than one item.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == KIND_TX)
        else $error("non-final item that is not a transmit");

    // Every slot lies inside the ring.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[3:0] < 4'(WINDOW))
        else $error("slot outside the window");

endmodule

bind go_back_n_send_window_core gbn_checker u_gbn_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
